/* rtl/plm_pkg.sv */
// Shared constants, codes and types of the peak level meter.
`default_nettype none
package plm_pkg;

  localparam int MAX_CHANNELS = 16;
  localparam int SAMPLE_BITS  = 24;
  localparam int COEF_BITS    = 24;
  localparam int CH_W         = 4;
  localparam int CMD_W        = 3;
  localparam int CNT_W        = 5;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;
  localparam int FIFO_DEPTH   = 2;
  localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);
  localparam int PROD_W       = COEF_BITS + SAMPLE_BITS;

  localparam logic [CNT_W-1:0]      RST_CHANNEL_COUNT = CNT_W'(2);
  localparam logic [COEF_BITS-1:0]  RST_ATTACK        = COEF_BITS'(16501709);
  localparam logic [COEF_BITS-1:0]  RST_RELEASE       = COEF_BITS'(16775606);
  localparam logic [SAMPLE_BITS-1:0] RST_PRESENCE     = SAMPLE_BITS'(210);
  localparam logic [SAMPLE_BITS-1:0] RST_CLIP         = SAMPLE_BITS'(4194304);

  typedef enum logic [CMD_W-1:0] {
    CMD_METER       = 3'd0,
    CMD_CLIP_ONLY   = 3'd1,
    CMD_CLEAR_FLAGS = 3'd2,
    CMD_ZERO_LEVELS = 3'd3,
    CMD_TIMEOUT     = 3'd4
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_COUNT = 3'd0,
    CFG_ATTACK        = 3'd1,
    CFG_RELEASE       = 3'd2,
    CFG_PRESENCE      = 3'd3,
    CFG_CLIP          = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_METER,
    OP_CLIP,
    OP_CLEAR,
    OP_ZERO,
    OP_TIMEOUT
  } op_e;

  typedef struct packed {
    logic [CNT_W-1:0]       channel_count;
    logic [COEF_BITS-1:0]   attack_coeff;
    logic [COEF_BITS-1:0]   release_coeff;
    logic [SAMPLE_BITS-1:0] presence_thr;
    logic [SAMPLE_BITS-1:0] clip_thr;
  } cfg_t;

  typedef struct packed {
    op_e                    op;
    logic [CH_W-1:0]        channel;
    logic [SAMPLE_BITS-1:0] abs_val;
    logic                   above_presence;
    logic                   above_clip;
    logic                   block_end;
  } op_t;

  typedef struct packed {
    logic                   accepted;
    logic [SAMPLE_BITS-1:0] level;
    logic                   signal_present;
    logic                   channel_clipped;
    logic                   any_clipped;
  } res_t;

endpackage
`default_nettype wire

/* rtl/plm_if.sv */
// Stream interfaces for meter requests and meter results.
`default_nettype none
interface plm_in_if
  import plm_pkg::*;
();
  logic                          valid;
  logic                          ready;
  logic [CMD_W-1:0]              command;
  logic [CH_W-1:0]               channel;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          block_end;

  modport source (output valid, output command, output channel, output sample,
                  output block_end, input ready);
  modport sink (input valid, input command, input channel, input sample,
                input block_end, output ready);
endinterface

interface plm_out_if
  import plm_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic                   accepted;
  logic [SAMPLE_BITS-1:0] level;
  logic                   signal_present;
  logic                   channel_clipped;
  logic                   any_clipped;

  modport source (output valid, output accepted, output level, output signal_present,
                  output channel_clipped, output any_clipped, input ready);
  modport sink (input valid, input accepted, input level, input signal_present,
                input channel_clipped, input any_clipped, output ready);
endinterface
`default_nettype wire

/* rtl/plm_front.sv */
// Front end: takes requests, decodes the command and compares the sample magnitude.
`default_nettype none
module plm_front
  import plm_pkg::*;
(
  plm_in_if.sink    smp_i,
  input  var cfg_t  cfg_i,
  input  wire logic q_full_i,
  output logic      push_o,
  output op_t       op_o
);

  logic [SAMPLE_BITS-1:0] raw;
  logic [SAMPLE_BITS-1:0] abs_val;
  logic                   used;

  assign smp_i.ready = !q_full_i;
  assign push_o      = smp_i.valid && !q_full_i;

  assign raw = smp_i.sample;
  // most negative sample maps to 2^(SAMPLE_BITS-1), still fits unsigned
  assign abs_val = raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;
  // channel_count above the channel range simply covers every channel
  assign used = {1'b0, smp_i.channel} < cfg_i.channel_count;

  always_comb begin
    op_o.channel        = smp_i.channel;
    op_o.abs_val        = abs_val;
    op_o.above_presence = abs_val > cfg_i.presence_thr;
    op_o.above_clip     = abs_val > cfg_i.clip_thr;
    op_o.block_end      = smp_i.block_end;
    unique case (smp_i.command)
      CMD_METER:       op_o.op = used ? OP_METER : OP_NONE;
      CMD_CLIP_ONLY:   op_o.op = used ? OP_CLIP : OP_NONE;
      CMD_CLEAR_FLAGS: op_o.op = OP_CLEAR;
      CMD_ZERO_LEVELS: op_o.op = OP_ZERO;
      CMD_TIMEOUT:     op_o.op = OP_TIMEOUT;
      default:         op_o.op = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/plm_fifo.sv */
// Short queue of decoded requests between front end and execute stage.
`default_nettype none
module plm_fifo
  import plm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  var op_t   data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output op_t       data_o
);

  op_t                   mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == FIFO_CNT_W'(FIFO_DEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

/* rtl/plm_back.sv */
// Execute stage: envelope update, flag bookkeeping and the registered result.
`default_nettype none
module plm_back
  import plm_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  var cfg_t   cfg_i,
  input  wire logic  q_valid_i,
  input  var op_t    op_i,
  output logic       pop_o,
  plm_out_if.source  res_o
);

  logic [SAMPLE_BITS-1:0]  env_q [MAX_CHANNELS];
  logic [SAMPLE_BITS-1:0]  env_d [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] sig_q, sig_d;
  logic [MAX_CHANNELS-1:0] clip_q, clip_d;
  logic [MAX_CHANNELS-1:0] blk_sig_q, blk_sig_d;
  logic [MAX_CHANNELS-1:0] blk_clip_q, blk_clip_d;
  logic                    out_vld_q;
  res_t                    out_q, res_d;

  logic [SAMPLE_BITS-1:0]  lv;
  logic                    rise;
  logic [PROD_W-1:0]       mul_a, mul_b, prod;
  logic [SAMPLE_BITS-1:0]  prod_hi;
  logic [SAMPLE_BITS-1:0]  new_lv;
  logic [MAX_CHANNELS-1:0] ch_bit;
  logic [MAX_CHANNELS-1:0] use_mask;
  logic [MAX_CHANNELS-1:0] bs, bc;

  assign pop_o = q_valid_i && (!out_vld_q || res_o.ready);

  // one shared multiplier: attack step on a rise, release decay otherwise
  assign lv      = env_q[op_i.channel];
  assign rise    = op_i.abs_val > lv;
  assign mul_a   = {{SAMPLE_BITS{1'b0}}, rise ? cfg_i.attack_coeff : cfg_i.release_coeff};
  assign mul_b   = {{COEF_BITS{1'b0}}, rise ? (op_i.abs_val - lv) : lv};
  assign prod    = mul_a * mul_b;
  assign prod_hi = prod[COEF_BITS +: SAMPLE_BITS];
  assign new_lv  = rise ? (op_i.abs_val - prod_hi) : prod_hi;

  assign ch_bit = {{(MAX_CHANNELS-1){1'b0}}, 1'b1} << op_i.channel;

  always_comb begin
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      use_mask[i] = CNT_W'(i) < cfg_i.channel_count;
    end
  end

  always_comb begin
    env_d      = env_q;
    sig_d      = sig_q;
    clip_d     = clip_q;
    blk_sig_d  = blk_sig_q;
    blk_clip_d = blk_clip_q;
    bs         = blk_sig_q | (op_i.above_presence ? ch_bit : '0);
    bc         = blk_clip_q | ((op_i.above_clip || clip_q[op_i.channel]) ? ch_bit : '0);
    if (pop_o) begin
      unique case (op_i.op)
        OP_METER: begin
          env_d[op_i.channel] = new_lv;
          if (op_i.block_end) begin
            sig_d      = (sig_q & ~ch_bit) | (bs & ch_bit);
            clip_d     = (clip_q & ~ch_bit) | (bc & ch_bit);
            blk_sig_d  = bs & ~ch_bit;
            blk_clip_d = bc & ~ch_bit;
          end else begin
            blk_sig_d  = bs;
            blk_clip_d = bc;
          end
        end
        OP_CLIP: begin
          if (op_i.above_clip) begin
            clip_d = clip_q | ch_bit;
          end
        end
        OP_CLEAR: begin
          sig_d      = '0;
          clip_d     = '0;
          blk_sig_d  = '0;
          blk_clip_d = '0;
        end
        OP_ZERO: begin
          for (int i = 0; i < MAX_CHANNELS; i++) begin
            env_d[i] = '0;
          end
        end
        OP_TIMEOUT: begin
          sig_d = '0;
          for (int i = 0; i < MAX_CHANNELS; i++) begin
            env_d[i] = '0;
          end
        end
        OP_NONE: begin
        end
        default: begin
        end
      endcase
    end
    res_d.accepted        = op_i.op != OP_NONE;
    res_d.level           = env_d[op_i.channel];
    res_d.signal_present  = sig_d[op_i.channel];
    res_d.channel_clipped = clip_d[op_i.channel];
    res_d.any_clipped     = |(clip_d & use_mask);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        env_q[i] <= '0;
      end
      sig_q      <= '0;
      clip_q     <= '0;
      blk_sig_q  <= '0;
      blk_clip_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      env_q      <= env_d;
      sig_q      <= sig_d;
      clip_q     <= clip_d;
      blk_sig_q  <= blk_sig_d;
      blk_clip_q <= blk_clip_d;
      if (pop_o) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= res_d;
    end
  end

  assign res_o.valid           = out_vld_q;
  assign res_o.accepted        = out_q.accepted;
  assign res_o.level           = out_q.level;
  assign res_o.signal_present  = out_q.signal_present;
  assign res_o.channel_clipped = out_q.channel_clipped;
  assign res_o.any_clipped     = out_q.any_clipped;

endmodule
`default_nettype wire

/* rtl/peak_level_meter_with_clip_detect_unit.sv */
// Top level of the peak level meter: config registers, front end, queue, execute stage.
// A request is written into the queue when it is taken; the execute stage pops it and
// loads the output register, and waits while the previous result is not yet accepted.
// Throughput: one request per cycle while results are accepted; the envelope update
// reads and writes the channel's level with one shared 24x24 multiplier.
// Reset: levels and all flags clear at once, registers return to their defaults.
`default_nettype none
module peak_level_meter_with_clip_detect_unit
  import plm_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  plm_in_if.sink                     smp_i,
  plm_out_if.source                  res_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg_q;
  op_t  op_in, op_out;
  logic push, pop, q_full, q_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_count <= RST_CHANNEL_COUNT;
      cfg_q.attack_coeff  <= RST_ATTACK;
      cfg_q.release_coeff <= RST_RELEASE;
      cfg_q.presence_thr  <= RST_PRESENCE;
      cfg_q.clip_thr      <= RST_CLIP;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data_i[CNT_W-1:0];
        CFG_ATTACK:        cfg_q.attack_coeff  <= cfg_data_i[COEF_BITS-1:0];
        CFG_RELEASE:       cfg_q.release_coeff <= cfg_data_i[COEF_BITS-1:0];
        CFG_PRESENCE:      cfg_q.presence_thr  <= cfg_data_i[SAMPLE_BITS-1:0];
        CFG_CLIP:          cfg_q.clip_thr      <= cfg_data_i[SAMPLE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  plm_front u_front (
    .smp_i    (smp_i),
    .cfg_i    (cfg_q),
    .q_full_i (q_full),
    .push_o   (push),
    .op_o     (op_in)
  );

  plm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (op_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (op_out)
  );

  plm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .op_i      (op_out),
    .pop_o     (pop),
    .res_o     (res_o)
  );

endmodule
`default_nettype wire
